/* rtl/tcp_source_prefix_blocklist_filter_macros.svh */
// Assertion macros for the source-prefix blocklist filter.
// Used by the controller; no other dependencies.
`ifndef TCP_SOURCE_PREFIX_BLOCKLIST_FILTER_MACROS_SVH
`define TCP_SOURCE_PREFIX_BLOCKLIST_FILTER_MACROS_SVH

// same-cycle implication
`define TSPBF_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("tspbf assertion failed");

// next-cycle implication
`define TSPBF_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("tspbf assertion failed");

`endif

/* rtl/tspbf_pkg.sv */
// Shared types and constants for the source-prefix blocklist filter.
// No dependencies.
package tspbf_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W         = 4;

  localparam logic [1:0] ACT_BYTE  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [1:0] VERD_PASS  = 2'd0;
  localparam logic [1:0] VERD_DROP  = 2'd1;
  localparam logic [1:0] VERD_ABORT = 2'd2;
  localparam logic [1:0] VERD_READ  = 2'd3;

  localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
  localparam logic [7:0]  PROTO_TCP   = 8'h06;
  localparam logic [15:0] PORT_RESET  = 16'd8080;
  localparam logic [6:0]  COUNT_MAX   = 7'd127;

  localparam logic       REG_GROUP = 1'b0;
  localparam logic       REG_PORT  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASS,
    ST_SCAN,
    ST_COMMIT,
    ST_RESULT
  } tspbf_state_t;

  typedef struct packed {
    logic cap_byte;
    logic write_rule;
    logic start_read;
    logic classify;
    logic scan_step;
    logic commit;
    logic load_out;
  } tspbf_cmd_t;

  typedef struct packed {
    logic need_lookup;
    logic scan_last;
    logic out_free;
  } tspbf_status_t;

endpackage

/* rtl/tcp_source_prefix_blocklist_filter.sv */
// Top level of the TCP source-prefix blocklist filter: APB registers,
// controller and datapath. Depends on tspbf_pkg, tspbf_ctrl, tspbf_dp.
//
// Usage: the request channel (in_valid/in_stall) carries one action per
// request: a frame byte, a rule-table write or a drop-counter read. The
// result channel (out_valid/out_stall) gives one verdict per frame (on the
// byte flagged last) and one reply per counter read.
// Frame bytes that are not last, and table writes, are taken one per cycle
// while the block is idle. A last byte goes through classify, then, when a
// table lookup is needed, a scan of the 16-entry table (one entry compared
// per cycle) and a commit step, then the result step; a counter read goes
// straight to the result step. The result is loaded into the output register as the block leaves its result step.
// The output register holds a result while the receiver stalls; the block
// keeps taking frame bytes and writes meanwhile, and waits in its result
// step only if a second result is ready before the first was taken.
// Reset (rst_n low, synchronous) clears the byte count, entry valid bits,
// output valid and state, and sets group_value 0 and blocked_port 8080.
// Configuration via APB: register 0 at 0x0 is group_value, register 1 at
// 0x4 is blocked_port; write only while the block is idle.
module tcp_source_prefix_blocklist_filter
  import tspbf_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    in_action,
  input  logic [7:0]    in_data_byte,
  input  logic          in_last_byte,
  input  logic [3:0]    in_rule_index,
  input  logic [31:0]   in_rule_address,
  input  logic [5:0]    in_rule_length,
  input  logic          in_rule_enable,
  input  logic [31:0]   in_rule_start_count,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [1:0]    out_verdict,
  output logic          out_rule_hit,
  output logic [3:0]    out_hit_index,
  output logic [31:0]   out_drop_count,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [2:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);

  logic [31:0]   group_value_r;
  logic [15:0]   blocked_port_r;
  logic          cfg_wr;
  tspbf_cmd_t    cmd;
  tspbf_status_t status;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_value_r  <= 32'd0;
      blocked_port_r <= PORT_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_GROUP) group_value_r  <= cfg_pwdata;
      else                           blocked_port_r <= cfg_pwdata[15:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_PORT) ? {16'd0, blocked_port_r}
                                                 : group_value_r;

  tspbf_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_action    (in_action),
    .in_last_byte (in_last_byte),
    .in_stall     (in_stall),
    .status       (status),
    .cmd          (cmd)
  );

  tspbf_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_data_byte        (in_data_byte),
    .in_last_byte        (in_last_byte),
    .in_rule_index       (in_rule_index),
    .in_rule_address     (in_rule_address),
    .in_rule_length      (in_rule_length),
    .in_rule_enable      (in_rule_enable),
    .in_rule_start_count (in_rule_start_count),
    .group_value         (group_value_r),
    .blocked_port        (blocked_port_r),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_verdict         (out_verdict),
    .out_rule_hit        (out_rule_hit),
    .out_hit_index       (out_hit_index),
    .out_drop_count      (out_drop_count)
  );

endmodule

/* rtl/tspbf_dp.sv */
// Datapath: header capture, rule table, prefix scan, result and output regs.
// Depends on tspbf_pkg.
module tspbf_dp
  import tspbf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  tspbf_cmd_t           cmd,
  output tspbf_status_t        status,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_last_byte,
  input  logic [IDX_W-1:0]     in_rule_index,
  input  logic [31:0]          in_rule_address,
  input  logic [5:0]           in_rule_length,
  input  logic                 in_rule_enable,
  input  logic [31:0]          in_rule_start_count,
  input  logic [31:0]          group_value,
  input  logic [15:0]          blocked_port,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_verdict,
  output logic                 out_rule_hit,
  output logic [IDX_W-1:0]     out_hit_index,
  output logic [31:0]          out_drop_count
);

  // header fields captured as the bytes go by
  logic [6:0]  byte_count_r, byte_count_nxt;
  logic [6:0]  len_r;
  logic [7:0]  et_hi_r, et_lo_r, proto_r, port_hi_r, port_lo_r;
  logic [3:0]  ihl_r;
  logic [31:0] src_r;

  logic [TABLE_ENTRIES-1:0] ent_valid_r;
  logic [31:0] ent_prefix_r [TABLE_ENTRIES];
  logic [5:0]  ent_len_r    [TABLE_ENTRIES];
  logic [31:0] ent_drops_r  [TABLE_ENTRIES];

  logic [IDX_W-1:0] scan_idx_r, best_r;
  logic [5:0]       best_len_r;
  logic             found_r;

  logic [1:0]       res_verdict_r;
  logic             res_hit_r;
  logic [IDX_W-1:0] res_index_r;
  logic [31:0]      res_count_r;

  logic             out_valid_r;
  logic [1:0]       out_verdict_r;
  logic             out_hit_r;
  logic [IDX_W-1:0] out_index_r;
  logic [31:0]      out_count_r;

  logic [6:0]  tcp_off;
  logic [6:0]  len_now;
  logic        cls_abort, cls_lookup;
  logic [5:0]  sc_len;
  logic [31:0] sc_mask;
  logic        sc_match;
  logic [IDX_W-1:0] rd_idx;
  logic [31:0] drops_rd, drops_inc;

  assign tcp_off = 7'd14 + {1'b0, ihl_r, 2'b00};
  assign len_now = (byte_count_r < COUNT_MAX) ? byte_count_r + 7'd1 : COUNT_MAX;
  assign byte_count_nxt = in_last_byte ? 7'd0 : len_now;

  always_comb begin
    cls_abort  = 1'b0;
    cls_lookup = 1'b0;
    if (len_r < 7'd14) begin
      cls_abort = 1'b1;
    end else if ({et_hi_r, et_lo_r} != ETYPE_IPV4) begin
      cls_abort = 1'b0;
    end else if (len_r < 7'd34) begin
      cls_abort = 1'b1;
    end else if (proto_r != PROTO_TCP) begin
      cls_abort = 1'b0;
    end else if (len_r < tcp_off + 7'd20) begin
      cls_abort = 1'b1;
    end else if ({port_hi_r, port_lo_r} == blocked_port) begin
      cls_lookup = 1'b1;
    end
  end

  // one table entry per cycle
  assign sc_len   = (ent_len_r[scan_idx_r] > 6'd32) ? 6'd32 : ent_len_r[scan_idx_r];
  assign sc_mask  = 32'hFFFF_FFFF << (6'd32 - sc_len);
  assign sc_match = ent_valid_r[scan_idx_r] &&
                    (((src_r ^ ent_prefix_r[scan_idx_r]) & sc_mask) == 32'd0);

  assign rd_idx    = cmd.commit ? best_r : in_rule_index;
  assign drops_rd  = ent_drops_r[rd_idx];
  assign drops_inc = drops_rd + 32'd1;

  assign status.need_lookup = cls_lookup;
  assign status.scan_last   = (scan_idx_r == IDX_W'(TABLE_ENTRIES - 1));
  assign status.out_free    = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= 7'd0;
    end else if (cmd.cap_byte) begin
      byte_count_r <= byte_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_byte) begin
      if (in_last_byte) len_r <= len_now;
      if (byte_count_r == 7'd12) et_hi_r <= in_data_byte;
      if (byte_count_r == 7'd13) et_lo_r <= in_data_byte;
      if (byte_count_r == 7'd14) ihl_r <= in_data_byte[3:0];
      if (byte_count_r == 7'd23) proto_r <= in_data_byte;
      if (byte_count_r == 7'd26) src_r[31:24] <= in_data_byte;
      if (byte_count_r == 7'd27) src_r[23:16] <= in_data_byte;
      if (byte_count_r == 7'd28) src_r[15:8]  <= in_data_byte;
      if (byte_count_r == 7'd29) src_r[7:0]   <= in_data_byte;
      if (byte_count_r == tcp_off + 7'd2) port_hi_r <= in_data_byte;
      if (byte_count_r == tcp_off + 7'd3) port_lo_r <= in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= '0;
    end else if (cmd.write_rule) begin
      ent_valid_r[in_rule_index] <= in_rule_enable;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_rule) begin
      ent_prefix_r[in_rule_index] <= in_rule_address;
      ent_len_r[in_rule_index]    <= in_rule_length;
      ent_drops_r[in_rule_index]  <= in_rule_start_count;
    end else if (cmd.commit && found_r && group_value == 32'd1) begin
      ent_drops_r[best_r] <= drops_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.classify) begin
      scan_idx_r    <= '0;
      found_r       <= 1'b0;
      best_r        <= '0;
      best_len_r    <= 6'd0;
      res_verdict_r <= cls_abort ? VERD_ABORT : VERD_PASS;
      res_hit_r     <= 1'b0;
      res_index_r   <= '0;
      res_count_r   <= 32'd0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_idx_r + 1'b1;
      // strict compare keeps the lowest index on equal lengths
      if (sc_match && (!found_r || sc_len > best_len_r)) begin
        found_r    <= 1'b1;
        best_r     <= scan_idx_r;
        best_len_r <= sc_len;
      end
    end else if (cmd.commit) begin
      if (found_r) begin
        res_hit_r   <= 1'b1;
        res_index_r <= best_r;
        if (group_value == 32'd1) begin
          res_verdict_r <= VERD_DROP;
          res_count_r   <= drops_inc;
        end else begin
          res_verdict_r <= VERD_PASS;
          res_count_r   <= drops_rd;
        end
      end
    end else if (cmd.start_read) begin
      res_verdict_r <= VERD_READ;
      res_hit_r     <= ent_valid_r[in_rule_index];
      res_index_r   <= in_rule_index;
      res_count_r   <= drops_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_verdict_r <= res_verdict_r;
      out_hit_r     <= res_hit_r;
      out_index_r   <= res_index_r;
      out_count_r   <= res_count_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_verdict    = out_verdict_r;
  assign out_rule_hit   = out_hit_r;
  assign out_hit_index  = out_index_r;
  assign out_drop_count = out_count_r;

endmodule

/* rtl/tspbf_ctrl.sv */
// Controller state machine: sequences capture, classify, table scan, commit, counter reads and result.
// Depends on tspbf_pkg and the assertion macro header.
`include "tcp_source_prefix_blocklist_filter_macros.svh"
module tspbf_ctrl
  import tspbf_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_action,
  input  logic          in_last_byte,
  output logic          in_stall,
  input  tspbf_status_t status,
  output tspbf_cmd_t    cmd
);

  tspbf_state_t state_r, state_nxt;
  logic         take;

  assign take = in_valid && (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (take && in_action == ACT_BYTE && in_last_byte) state_nxt = ST_CLASS;
        else if (take && in_action == ACT_READ) state_nxt = ST_RESULT;
      end
      ST_CLASS:  state_nxt = status.need_lookup ? ST_SCAN : ST_RESULT;
      ST_SCAN:   if (status.scan_last) state_nxt = ST_COMMIT;
      ST_COMMIT: state_nxt = ST_RESULT;
      ST_RESULT: if (status.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall       = 1'b0;
        cmd.cap_byte   = take && (in_action == ACT_BYTE);
        cmd.write_rule = take && (in_action == ACT_WRITE);
        cmd.start_read = take && (in_action == ACT_READ);
      end
      ST_CLASS:  cmd.classify  = 1'b1;
      ST_SCAN:   cmd.scan_step = 1'b1;
      ST_COMMIT: cmd.commit    = 1'b1;
      ST_RESULT: cmd.load_out  = status.out_free;
      default:   cmd = '0;
    endcase
  end

  `TSPBF_ASSERT_NEXT(a_last_byte_classifies, clk, rst_n,
    cmd.cap_byte && in_last_byte, state_r == ST_CLASS)
  `TSPBF_ASSERT_NEXT(a_scan_ends_in_commit, clk, rst_n,
    cmd.scan_step && status.scan_last, state_r == ST_COMMIT)
  `TSPBF_ASSERT_NEXT(a_result_returns_idle, clk, rst_n,
    cmd.load_out, state_r == ST_IDLE && !in_stall)

endmodule

/* sim/tcp_source_prefix_blocklist_filter_test.sv */
// Testbench for the TCP source-prefix blocklist filter: random frames and
// rule-table requests checked against a cycle-free predictor.
// Depends on tspbf_pkg and the tcp_source_prefix_blocklist_filter RTL.
`timescale 1ns / 1ps

module tcp_source_prefix_blocklist_filter_test;
  import tspbf_pkg::*;

  localparam logic [2:0] ADDR_GROUP = 3'd0;
  localparam logic [2:0] ADDR_PORT  = 3'd4;
  localparam logic [1:0] ACT_NONE   = 2'd3;
  localparam int STORE_BYTES = 96;
  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE      = 40;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  data;
    logic        last;
    logic [3:0]  idx;
    logic [31:0] addr;
    logic [5:0]  plen;
    logic        en;
    logic [31:0] cnt;
  } req_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic        hit;
    logic [3:0]  idx;
    logic [31:0] count;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t cur_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_verdict;
  logic out_rule_hit;
  logic [3:0] out_hit_index;
  logic [31:0] out_drop_count;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  tcp_source_prefix_blocklist_filter uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_action(cur_req.action), .in_data_byte(cur_req.data),
    .in_last_byte(cur_req.last), .in_rule_index(cur_req.idx),
    .in_rule_address(cur_req.addr), .in_rule_length(cur_req.plen),
    .in_rule_enable(cur_req.en), .in_rule_start_count(cur_req.cnt),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_verdict(out_verdict), .out_rule_hit(out_rule_hit),
    .out_hit_index(out_hit_index), .out_drop_count(out_drop_count),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [31:0] group_word = 32'd0;
  logic [15:0] watched_port = PORT_RESET;
  logic [7:0]  frame_store [STORE_BYTES];
  logic [6:0]  frame_len = '0;
  logic        tbl_valid [TABLE_ENTRIES];
  logic [31:0] tbl_prefix [TABLE_ENTRIES];
  logic [5:0]  tbl_len [TABLE_ENTRIES];
  logic [31:0] tbl_drops [TABLE_ENTRIES];

  req_t     pending_q[$];
  verdict_t verdict_q[$];
  int errors = 0;
  int queued = 0;
  bit idle_on = 1'b1;
  int gap_left = 0;
  int stall_left = 0;
  int quiet = 0;

  initial for (int i = 0; i < TABLE_ENTRIES; i++) tbl_valid[i] = 1'b0;

  function automatic logic [31:0] mask_of(logic [5:0] l);
    int n;
    n = (l > 32) ? 32 : int'(l);
    return (n == 0) ? 32'd0 : (32'hFFFFFFFF << (32 - n));
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic judge_frame(input int n, output verdict_t v);
    int tcp, best, bestlen, l;
    logic [15:0] dport;
    logic [31:0] src;
    bit found;
    v = '{VERD_PASS, 1'b0, 4'd0, 32'd0};
    found = 0;
    best = 0;
    bestlen = 0;
    if (n < 14) begin
      v.verdict = VERD_ABORT;
    end else if ({frame_store[12], frame_store[13]} != ETYPE_IPV4) begin
      v.verdict = VERD_PASS;
    end else if (n < 34) begin
      v.verdict = VERD_ABORT;
    end else if (frame_store[23] != PROTO_TCP) begin
      v.verdict = VERD_PASS;
    end else begin
      tcp = 14 + int'(frame_store[14][3:0]) * 4;
      if (n < tcp + 20) begin
        v.verdict = VERD_ABORT;
      end else begin
        dport = {frame_store[tcp + 2], frame_store[tcp + 3]};
        src = {frame_store[26], frame_store[27], frame_store[28], frame_store[29]};
        if (dport == watched_port) begin
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            l = (tbl_len[i] > 32) ? 32 : int'(tbl_len[i]);
            if (tbl_valid[i] && ((src ^ tbl_prefix[i]) & mask_of(tbl_len[i])) == 0 &&
                (!found || l > bestlen)) begin
              found = 1;
              best = i;
              bestlen = l;
            end
          end
          if (found) begin
            if (group_word == 32'd1) begin
              tbl_drops[best] = tbl_drops[best] + 32'd1;
              v.verdict = VERD_DROP;
            end
            v.hit = 1'b1;
            v.idx = best[3:0];
            v.count = tbl_drops[best];
          end
        end
      end
    end
  endtask

  task automatic apply_request(input req_t r);
    verdict_t v;
    logic [6:0] n;
    case (r.action)
      ACT_BYTE: begin
        if (frame_len < STORE_BYTES) frame_store[frame_len] = r.data;
        n = (frame_len < COUNT_MAX) ? frame_len + 7'd1 : COUNT_MAX;
        if (!r.last) begin
          frame_len = n;
        end else begin
          frame_len = '0;
          judge_frame(int'(n), v);
          verdict_q.push_back(v);
        end
      end
      ACT_WRITE: begin
        tbl_valid[r.idx] = r.en;
        tbl_prefix[r.idx] = r.addr;
        tbl_len[r.idx] = r.plen;
        tbl_drops[r.idx] = r.cnt;
      end
      ACT_READ: verdict_q.push_back('{VERD_READ, tbl_valid[r.idx], r.idx, tbl_drops[r.idx]});
      default: ;
    endcase
  endtask

  function automatic req_t rand_req();
    req_t r;
    r.action = ACT_BYTE;
    r.data = 8'($urandom);
    r.last = 1'($urandom);
    r.idx = 4'($urandom);
    r.addr = $urandom;
    r.plen = 6'($urandom);
    r.en = 1'($urandom);
    r.cnt = $urandom;
    return r;
  endfunction

  task automatic push_req(input req_t r);
    pending_q.push_back(r);
    queued++;
  endtask

  task automatic add_table_op(input logic [1:0] act, input int idx);
    req_t r;
    int p;
    r = rand_req();
    r.action = act;
    if (idx >= 0) r.idx = 4'(idx);
    if (act == ACT_WRITE) begin
      p = $urandom_range(0, 99);
      r.plen = 6'((p < 70) ? $urandom_range(4, 32) : $urandom_range(0, 63));
      r.en = ($urandom_range(0, 99) < 85);
      if ($urandom_range(0, 9) == 0) r.cnt = 32'hFFFFFFFF - $urandom_range(0, 2);
      // keep prefixes in a narrow space so frames hit them often
      if ($urandom_range(0, 3) != 0) r.addr[31:24] = 8'h0A;
    end
    push_req(r);
  endtask

  // kind: 0 random, 1 shorter than Ethernet, 2 not IPv4, 3 short IPv4,
  // 4 not TCP, 5 well-formed TCP frame, 6 long frame
  task automatic add_frame(input int kind);
    logic [7:0] fb[];
    int ihl, tcp, total, k, p;
    logic [31:0] ip;
    req_t r;
    ihl = ($urandom_range(0, 99) < 80) ? 5 : $urandom_range(0, 15);
    tcp = 14 + ihl * 4;
    total = tcp + 20 + $urandom_range(0, 24);
    p = $urandom_range(0, 99);
    if (kind == 0 && p < 10) total = $urandom_range(1, tcp + 21);
    if ((kind == 0 && p >= 95) || kind == 6) total = $urandom_range(96, 140);
    if (kind == 1) total = $urandom_range(1, 13);
    if (kind == 3) total = $urandom_range(14, 33);
    fb = new[total];
    foreach (fb[i]) fb[i] = 8'($urandom);
    k = $urandom_range(0, TABLE_ENTRIES - 1);
    ip = $urandom;
    if ($urandom_range(0, 3) != 0 && tbl_valid[k])
      ip = (tbl_prefix[k] & mask_of(tbl_len[k])) | (ip & ~mask_of(tbl_len[k]));
    if (total > 13 && (kind != 2) && (kind != 0 || $urandom_range(0, 9) != 0)) begin
      fb[12] = ETYPE_IPV4[15:8];
      fb[13] = ETYPE_IPV4[7:0];
    end
    if (kind == 2 && total > 13) fb[13] = 8'h06;
    if (total > 14) fb[14] = {4'h4, ihl[3:0]};
    if (total > 23 && kind != 4 && (kind != 0 || $urandom_range(0, 9) != 0))
      fb[23] = PROTO_TCP;
    if (kind == 4 && total > 23) fb[23] = 8'h11;
    for (int i = 0; i < 4; i++) if (26 + i < total) fb[26 + i] = ip[31 - 8 * i -: 8];
    if (tcp + 3 < total && (kind != 0 || $urandom_range(0, 99) < 85)) begin
      fb[tcp + 2] = watched_port[15:8];
      fb[tcp + 3] = watched_port[7:0];
    end
    for (int i = 0; i < total; i++) begin
      if (kind == 0 && $urandom_range(0, 99) < 3)
        add_table_op($urandom_range(0, 1) ? ACT_WRITE : ACT_READ, -1);
      r = rand_req();
      r.data = fb[i];
      r.last = (i == total - 1);
      push_req(r);
    end
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] a, input logic [31:0] d);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= a;
    cfg_pwdata <= d;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (a == ADDR_GROUP) group_word = d;
    else watched_port = d[15:0];
  endtask

  task automatic random_phase(input logic [31:0] g, input logic [15:0] port, input int n);
    int r;
    drain();
    cfg_write(ADDR_GROUP, g);
    cfg_write(ADDR_PORT, {16'd0, port});
    queued = 0;
    while (queued < n) begin
      r = $urandom_range(0, 99);
      if (r < 72) add_frame(0);
      else if (r < 84) add_table_op(ACT_WRITE, -1);
      else if (r < 97) add_table_op(ACT_READ, -1);
      else add_table_op(ACT_NONE, -1);
    end
  endtask

  // stimulus
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // every entry gets written first, so no read sees an unwritten counter
    for (int i = 0; i < TABLE_ENTRIES; i++) add_table_op(ACT_WRITE, i);
    add_frame(1);
    add_frame(2);
    add_frame(3);
    add_frame(4);
    add_frame(5);
    add_frame(6);
    add_table_op(ACT_READ, TABLE_ENTRIES - 1);
    add_table_op(ACT_NONE, 0);
    random_phase(32'd1, PORT_RESET, 200);
    random_phase(32'd1, 16'd0, 200);
    random_phase(32'hFFFFFFFF, 16'hFFFF, 200);
    random_phase(32'd1, 16'($urandom), 200);
    random_phase(32'd2, 16'($urandom), 200);
    random_phase(32'd1, PORT_RESET, 200);
    drain();
    if (errors == 0) $display("** tcp_source_prefix_blocklist_filter: PASSED **");
    else $display("** tcp_source_prefix_blocklist_filter: FAILED **");
    $finish;
  end

  // request driver; prediction happens as each request is taken
  always @(posedge clk) begin
    if (in_valid && !in_stall) apply_request(cur_req);
    if ($urandom_range(0, 199) == 0) idle_on = !idle_on;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        cur_req <= pending_q.pop_front();
        in_valid <= 1'b1;
        gap_left <= idle_on ? pick_gap() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall and checker
  always @(posedge clk) begin
    verdict_t e;
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (idle_on && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected result: verdict %0d", out_verdict);
        errors++;
      end else begin
        e = verdict_q.pop_front();
        if (out_verdict !== e.verdict) begin
          $error("verdict: expected %0d, got %0d", e.verdict, out_verdict);
          errors++;
        end
        if (out_rule_hit !== e.hit) begin
          $error("rule_hit: expected %0d, got %0d", e.hit, out_rule_hit);
          errors++;
        end
        if (out_hit_index !== e.idx) begin
          $error("hit_index: expected %0d, got %0d", e.idx, out_hit_index);
          errors++;
        end
        if (out_drop_count !== e.count) begin
          $error("drop_count: expected %0h, got %0h", e.count, out_drop_count);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no request or result taken
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("** tcp_source_prefix_blocklist_filter: FAILED **");
        $finish;
      end
    end
  end

endmodule
